// ===== rtl/sbcf_pkg.sv =====
package sbcf_pkg;

    // Fixed field widths of the stream payload
    localparam int POS_W    = 16;
    localparam int DIM_W    = 7;
    localparam int SYM_W    = 16;
    localparam int CIDX_W   = 15;
    localparam int CELL_W   = 32;
    localparam int VIEW_W   = 12;
    localparam int SCOLS_W  = 9;
    localparam int SROWS_W  = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;
    localparam int IN_DW    = 96;
    localparam int OUT_DW   = 32;

    // Working width of signed screen coordinates: ceil of a 16-bit position,
    // minus a 12-bit view offset, plus a sprite column offset
    localparam int COORD_W  = 19;

    localparam int MIN_COLS = 20;
    localparam int MIN_ROWS = 10;

    localparam logic [SYM_W-1:0] SPACE_SYMBOL = 16'h0020;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_DRAW   = 3'd1,
        ACT_START  = 3'd2,
        ACT_SPRITE = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CLIP    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_VIEW_X = 2'd0,
        REG_VIEW_Y = 2'd1,
        REG_COLS   = 2'd2,
        REG_ROWS   = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COORD,
        S_MUL,
        S_WR0,
        S_WR1,
        S_RCHK,
        S_RWAIT,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// ===== rtl/sbcf_store.sv =====
module sbcf_store #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [sbcf_pkg::CELL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [sbcf_pkg::CELL_W-1:0] o_rdata
);
    import sbcf_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sprite_blit_char_framebuffer_core.sv =====
// Character-cell frame store with pixel plotting and sprite blitting.
//
// Input stream (s_axis): one command per transfer, action in tuser.
// Output stream (m_axis): one result per command; status in tuser,
// read symbol/color in tdata, sprite_done in tlast.
// APB port: view_x, view_y, screen_cols, screen_rows at 0x0/0x4/0x8/0xC.
//
// Commands run one at a time through a small sequencer around one shared
// multiply-add (row * cols + offset) and the single store write port.
// Draw pixel / opaque sprite pixel: coordinate, multiply, two cell writes,
// result; a new command waits for the result. Read cell: coordinate,
// multiply, range check, store read, result. Sprite start, transparent or
// ignored: coordinate, result. Clear: every cell, one written per cycle.
//
// Reset restores the register defaults and closes any open sprite; store
// contents are undefined until the first clear. A finished result sits in
// the output register while the next command is taken; if the receiver
// still stalls when that command finishes, the block waits for it.
module sprite_blit_char_framebuffer_core #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 128,
    parameter int MAX_SPRITE = 64,
    parameter int FRAC_BITS  = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [38:32] sprite_width,
    // [45:39] sprite_height, [46] flip, [47] active, [63:48] symbol,
    // [79:64] color, [94:80] cell_index, [95] zero
    input  logic [sbcf_pkg::IN_DW-1:0]   s_axis_tdata,
    // [2:0] action
    input  logic [2:0]                   s_axis_tuser,
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [15:0] read_symbol, [31:16] read_color
    output logic [sbcf_pkg::OUT_DW-1:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]                   m_axis_tuser,
    // sprite_done
    output logic                         m_axis_tlast,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sbcf_pkg::APB_AW-1:0]  paddr,
    input  logic [sbcf_pkg::APB_DW-1:0]  pwdata,
    output logic [sbcf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import sbcf_pkg::*;

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CLW   = $clog2(MAX_COLS + 1);
    localparam int RLW   = $clog2(MAX_ROWS + 1);
    localparam int SW    = $clog2(MAX_SPRITE + 1);
    localparam int PW    = RLW + CLW + 1;
    localparam logic signed [COORD_W-1:0] RND = COORD_W'((1 << FRAC_BITS) - 1);

    // ---------------- configuration registers ----------------
    logic signed [VIEW_W-1:0]  r_view_x, r_view_y;
    logic [SCOLS_W-1:0]        r_screen_cols;
    logic [SROWS_W-1:0]        r_screen_rows;
    logic                      cfg_wr;
    t_reg_idx                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x      <= '0;
            r_view_y      <= '0;
            r_screen_cols <= SCOLS_W'(160);
            r_screen_rows <= SROWS_W'(50);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_VIEW_X: r_view_x      <= pwdata[VIEW_W-1:0];
                REG_VIEW_Y: r_view_y      <= pwdata[VIEW_W-1:0];
                REG_COLS:   r_screen_cols <= pwdata[SCOLS_W-1:0];
                REG_ROWS:   r_screen_rows <= pwdata[SROWS_W-1:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_VIEW_X: prdata = {{(APB_DW-VIEW_W){r_view_x[VIEW_W-1]}}, r_view_x};
            REG_VIEW_Y: prdata = {{(APB_DW-VIEW_W){r_view_y[VIEW_W-1]}}, r_view_y};
            REG_COLS:   prdata = {{(APB_DW-SCOLS_W){1'b0}}, r_screen_cols};
            REG_ROWS:   prdata = {{(APB_DW-SROWS_W){1'b0}}, r_screen_rows};
        endcase
    end

    // effective screen size: raised to the minimum, saturated to the store
    logic [31:0]    cols_raw, rows_raw;
    logic [CLW-1:0] eff_cols;
    logic [RLW-1:0] eff_rows;

    always_comb begin
        cols_raw = 32'(r_screen_cols);
        if (cols_raw < 32'(MIN_COLS)) cols_raw = 32'(MIN_COLS);
        if (cols_raw > 32'(MAX_COLS)) cols_raw = 32'(MAX_COLS);
        rows_raw = 32'(r_screen_rows);
        if (rows_raw < 32'(MIN_ROWS)) rows_raw = 32'(MIN_ROWS);
        if (rows_raw > 32'(MAX_ROWS)) rows_raw = 32'(MAX_ROWS);
        eff_cols = cols_raw[CLW-1:0];
        eff_rows = rows_raw[RLW-1:0];
    end

    // ---------------- sequencer and datapath registers ----------------
    t_state                    r_state, n_state;
    logic [2:0]                r_act, n_act;
    logic signed [POS_W-1:0]   r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [DIM_W-1:0]          r_sw, n_sw, r_sh, n_sh;
    logic                      r_flip, n_flip, r_active, n_active;
    logic [SYM_W-1:0]          r_symbol, n_symbol, r_color, n_color;
    logic [CIDX_W-1:0]         r_cidx, n_cidx;

    logic signed [COORD_W-1:0] r_origin_col, n_origin_col, r_origin_row, n_origin_row;
    logic [SW-1:0]             r_cur_w, n_cur_w, r_cur_h, n_cur_h;
    logic [SW-1:0]             r_src_col, n_src_col, r_src_row, n_src_row;
    logic                      r_mirror, n_mirror, r_open, n_open;

    logic signed [COORD_W-1:0] r_x, n_x, r_y, n_y;
    logic [PW-1:0]             r_prod, n_prod;
    logic                      r_clip, n_clip;
    logic [AW-1:0]             r_cnt, n_cnt;

    logic [1:0]                r_res_status, n_res_status;
    logic                      r_res_done, n_res_done;
    logic [SYM_W-1:0]          r_res_sym, n_res_sym, r_res_col, n_res_col;

    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_out_status, n_out_status;
    logic                      r_out_done, n_out_done;
    logic [SYM_W-1:0]          r_out_sym, n_out_sym, r_out_col, n_out_col;

    // store port
    logic                      st_we, st_re;
    logic [AW-1:0]             st_waddr, st_raddr;
    logic [CELL_W-1:0]         st_wdata, st_rdata;

    // shared multiply-add: a * cols + c
    logic [RLW-1:0]            mul_a;
    logic [CLW-1:0]            mul_c;
    logic [PW-1:0]             mul_res;

    always_comb begin
        if (r_act == ACT_READ) begin
            mul_a = eff_rows;
            mul_c = '0;
        end else begin
            mul_a = r_y[RLW-1:0];
            mul_c = {r_x[CLW-2:0], 1'b0};
        end
        mul_res = PW'(mul_a) * PW'(eff_cols) + PW'(mul_c);
    end

    // coordinate helpers
    logic signed [COORD_W-1:0] px_w, py_w, vx_w, vy_w, ceil_sum;
    logic signed [COORD_W-1:0] floor_x, floor_y, ceil_x;
    logic [SW-1:0]             dc;
    logic [31:0]               sw_sat, sh_sat;
    logic [31:0]               cidx_ext;
    logic [CLW-1:0]            half_cols;
    logic                      clip_now;

    always_comb begin
        px_w     = {{(COORD_W-POS_W){r_pos_x[POS_W-1]}}, r_pos_x};
        py_w     = {{(COORD_W-POS_W){r_pos_y[POS_W-1]}}, r_pos_y};
        vx_w     = {{(COORD_W-VIEW_W){r_view_x[VIEW_W-1]}}, r_view_x};
        vy_w     = {{(COORD_W-VIEW_W){r_view_y[VIEW_W-1]}}, r_view_y};
        floor_x  = px_w >>> FRAC_BITS;
        floor_y  = py_w >>> FRAC_BITS;
        ceil_sum = px_w + RND;
        ceil_x   = ceil_sum >>> FRAC_BITS;
        dc       = r_mirror ? SW'(r_cur_w - r_src_col - SW'(1)) : r_src_col;
        sw_sat   = (32'(r_sw) > 32'(MAX_SPRITE)) ? 32'(MAX_SPRITE) : 32'(r_sw);
        sh_sat   = (32'(r_sh) > 32'(MAX_SPRITE)) ? 32'(MAX_SPRITE) : 32'(r_sh);
        cidx_ext = 32'(r_cidx);
        half_cols = eff_cols >> 1;
        // pixel outside the logical screen
        clip_now = r_x[COORD_W-1] || r_y[COORD_W-1]
                || (unsigned'(r_x) >= {{(COORD_W-CLW){1'b0}}, half_cols})
                || (unsigned'(r_y) >= {{(COORD_W-RLW){1'b0}}, eff_rows});
    end

    assign s_axis_tready = (r_state == S_IDLE);

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_act        = r_act;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_sw         = r_sw;
        n_sh         = r_sh;
        n_flip       = r_flip;
        n_active     = r_active;
        n_symbol     = r_symbol;
        n_color      = r_color;
        n_cidx       = r_cidx;
        n_origin_col = r_origin_col;
        n_origin_row = r_origin_row;
        n_cur_w      = r_cur_w;
        n_cur_h      = r_cur_h;
        n_src_col    = r_src_col;
        n_src_row    = r_src_row;
        n_mirror     = r_mirror;
        n_open       = r_open;
        n_x          = r_x;
        n_y          = r_y;
        n_prod       = r_prod;
        n_clip       = r_clip;
        n_cnt        = r_cnt;
        n_res_status = r_res_status;
        n_res_done   = r_res_done;
        n_res_sym    = r_res_sym;
        n_res_col    = r_res_col;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_done   = r_out_done;
        n_out_sym    = r_out_sym;
        n_out_col    = r_out_col;
        st_we        = 1'b0;
        st_waddr     = r_prod[AW-1:0];
        st_wdata     = {r_color, r_symbol};
        st_re        = 1'b0;
        st_raddr     = cidx_ext[AW-1:0];

        // result taken by the receiver
        if (r_out_valid && m_axis_tready) n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act        = s_axis_tuser;
                    n_pos_x      = s_axis_tdata[15:0];
                    n_pos_y      = s_axis_tdata[31:16];
                    n_sw         = s_axis_tdata[38:32];
                    n_sh         = s_axis_tdata[45:39];
                    n_flip       = s_axis_tdata[46];
                    n_active     = s_axis_tdata[47];
                    n_symbol     = s_axis_tdata[63:48];
                    n_color      = s_axis_tdata[79:64];
                    n_cidx       = s_axis_tdata[94:80];
                    n_res_status = ST_OK;
                    n_res_done   = 1'b0;
                    n_res_sym    = '0;
                    n_res_col    = '0;
                    n_cnt        = '0;
                    n_state      = (s_axis_tuser == ACT_CLEAR) ? S_CLEAR : S_COORD;
                end
            end

            S_COORD: begin
                unique case (r_act)
                    ACT_DRAW: begin
                        n_x     = floor_x;
                        n_y     = floor_y;
                        n_state = S_MUL;
                    end
                    ACT_START: begin
                        n_cur_w      = SW'(sw_sat);
                        n_cur_h      = SW'(sh_sat);
                        n_origin_col = ceil_x - vx_w;
                        n_origin_row = floor_y - vy_w;
                        n_mirror     = r_flip;
                        n_src_col    = '0;
                        n_src_row    = '0;
                        n_open       = (sw_sat != 32'd0) && (sh_sat != 32'd0);
                        n_res_done   = (sw_sat == 32'd0) || (sh_sat == 32'd0);
                        n_state      = S_DONE;
                    end
                    ACT_SPRITE: begin
                        if (!r_open) begin
                            n_res_status = ST_IGNORED;
                            n_state      = S_DONE;
                        end else begin
                            n_x = r_origin_col + $signed({{(COORD_W-SW){1'b0}}, dc});
                            n_y = r_origin_row + $signed({{(COORD_W-SW){1'b0}}, r_src_row});
                            // advance the raster position
                            if (r_src_col + SW'(1) >= r_cur_w) begin
                                n_src_col = '0;
                                if (r_src_row + SW'(1) >= r_cur_h) begin
                                    n_src_row  = '0;
                                    n_open     = 1'b0;
                                    n_res_done = 1'b1;
                                end else begin
                                    n_src_row = r_src_row + SW'(1);
                                end
                            end else begin
                                n_src_col = r_src_col + SW'(1);
                            end
                            if (r_active) begin
                                n_state = S_MUL;
                            end else begin
                                n_res_status = ST_CLIP;
                                n_state      = S_DONE;
                            end
                        end
                    end
                    ACT_READ: begin
                        n_state = S_MUL;
                    end
                    default: begin
                        n_res_status = ST_IGNORED;
                        n_state      = S_DONE;
                    end
                endcase
            end

            S_MUL: begin
                n_prod  = mul_res;
                n_clip  = clip_now;
                n_state = (r_act == ACT_READ) ? S_RCHK : S_WR0;
            end

            S_WR0: begin
                if (r_clip) begin
                    n_res_status = ST_CLIP;
                    n_state      = S_DONE;
                end else begin
                    st_we   = 1'b1;
                    n_state = S_WR1;
                end
            end

            S_WR1: begin
                st_we    = 1'b1;
                st_waddr = r_prod[AW-1:0] + AW'(1);
                n_state  = S_DONE;
            end

            S_RCHK: begin
                if (cidx_ext >= 32'(r_prod)) begin
                    n_res_status = ST_IGNORED;
                    n_state      = S_DONE;
                end else begin
                    st_re   = 1'b1;
                    n_state = S_RWAIT;
                end
            end

            S_RWAIT: begin
                n_res_sym = st_rdata[SYM_W-1:0];
                n_res_col = st_rdata[CELL_W-1:SYM_W];
                n_state   = S_DONE;
            end

            S_CLEAR: begin
                // sweep the whole store, one cell per cycle
                st_we    = 1'b1;
                st_waddr = r_cnt;
                st_wdata = {{(CELL_W-SYM_W){1'b0}}, SPACE_SYMBOL};
                n_cnt    = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_done   = r_res_done;
                    n_out_sym    = r_res_sym;
                    n_out_col    = r_res_col;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state and sprite control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_origin_col <= '0;
            r_origin_row <= '0;
            r_cur_w      <= '0;
            r_cur_h      <= '0;
            r_src_col    <= '0;
            r_src_row    <= '0;
            r_mirror     <= 1'b0;
            r_open       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_origin_col <= n_origin_col;
            r_origin_row <= n_origin_row;
            r_cur_w      <= n_cur_w;
            r_cur_h      <= n_cur_h;
            r_src_col    <= n_src_col;
            r_src_row    <= n_src_row;
            r_mirror     <= n_mirror;
            r_open       <= n_open;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_pos_x      <= n_pos_x;
        r_pos_y      <= n_pos_y;
        r_sw         <= n_sw;
        r_sh         <= n_sh;
        r_flip       <= n_flip;
        r_active     <= n_active;
        r_symbol     <= n_symbol;
        r_color      <= n_color;
        r_cidx       <= n_cidx;
        r_x          <= n_x;
        r_y          <= n_y;
        r_prod       <= n_prod;
        r_clip       <= n_clip;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_done   <= n_res_done;
        r_res_sym    <= n_res_sym;
        r_res_col    <= n_res_col;
        r_out_status <= n_out_status;
        r_out_done   <= n_out_done;
        r_out_sym    <= n_out_sym;
        r_out_col    <= n_out_col;
    end

    sbcf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_col, r_out_sym};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_done;

endmodule
